>>> design/lts_pkg.sv
// ----------------------------------------------------------------------------
// Lap time speech sequencer package
// Shared widths, clip codes and the digit record that travels from the
// front end through the request queue to the clip sequencer.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int MINUTES_W = 10;
  localparam int SECONDS_W = 6;
  localparam int MILLIS_W  = 10;
  localparam int CLIP_W    = 6;
  localparam int DIGIT_W   = 4;
  localparam int REM_W     = 7;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [MINUTES_W-1:0] MINUTES_MAX = 10'd999;
  localparam logic [SECONDS_W-1:0] SECONDS_MAX = 6'd59;
  localparam logic [MILLIS_W-1:0]  MILLIS_MAX  = 10'd999;

  typedef logic [CLIP_W-1:0] clip_t;

  localparam clip_t CLIP_ZERO          = 6'd0;
  localparam clip_t CLIP_TEN           = 6'd10;
  localparam clip_t CLIP_TENS_BASE     = 6'd20;
  localparam clip_t CLIP_HUNDRED       = 6'd28;
  localparam clip_t CLIP_HUNDREDS_BASE = 6'd29;
  localparam clip_t CLIP_CENTO_E       = 6'd37;
  localparam clip_t CLIP_E             = 6'd38;
  localparam clip_t CLIP_POINT         = 6'd39;
  localparam clip_t CLIP_INTRO         = 6'd40;

  // One number, 0 to 999, split into decimal digits.
  typedef struct packed {
    logic [DIGIT_W-1:0] hun;
    logic [DIGIT_W-1:0] ten;
    logic [DIGIT_W-1:0] unit;
  } digits_t;

  // One announcement request after classification.
  typedef struct packed {
    digits_t mins;
    digits_t secs;
    digits_t msec;
  } lap_t;

endpackage

>>> design/lts_front.sv
// ----------------------------------------------------------------------------
// Lap time front end
// Saturates the three fields of an accepted request and splits each into
// hundreds, tens and units over two register stages.
// ----------------------------------------------------------------------------
module lts_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [lts_pkg::MINUTES_W-1:0] minutes,
  input  logic [lts_pkg::SECONDS_W-1:0] seconds,
  input  logic [lts_pkg::MILLIS_W-1:0]  millis,
  output logic                          push,
  output lts_pkg::lap_t                 lap,
  output logic [1:0]                    pending
);
  import lts_pkg::*;

  // Hundreds digit and remainder of a value below one thousand.
  function automatic logic [DIGIT_W+REM_W-1:0] split_hun(logic [MILLIS_W-1:0] v);
    logic [DIGIT_W-1:0]  h;
    logic [MILLIS_W-1:0] base;
    h    = '0;
    base = '0;
    for (int k = 1; k <= 9; k++) begin
      if (v >= MILLIS_W'(k * 100)) begin
        h    = DIGIT_W'(k);
        base = MILLIS_W'(k * 100);
      end
    end
    return {h, REM_W'(v - base)};
  endfunction

  // Tens and units digits of a value below one hundred.
  function automatic logic [2*DIGIT_W-1:0] split_ten(logic [REM_W-1:0] r);
    logic [DIGIT_W-1:0] t;
    logic [REM_W-1:0]   base;
    t    = '0;
    base = '0;
    for (int k = 1; k <= 9; k++) begin
      if (r >= REM_W'(k * 10)) begin
        t    = DIGIT_W'(k);
        base = REM_W'(k * 10);
      end
    end
    return {t, DIGIT_W'(r - base)};
  endfunction

  logic [MINUTES_W-1:0] min_sat;
  logic [SECONDS_W-1:0] sec_sat;
  logic [MILLIS_W-1:0]  ms_sat;

  logic                 s1_valid;
  logic [DIGIT_W-1:0]   s1_min_hun;
  logic [REM_W-1:0]     s1_min_rem;
  logic [SECONDS_W-1:0] s1_secs;
  logic [DIGIT_W-1:0]   s1_ms_hun;
  logic [REM_W-1:0]     s1_ms_rem;

  assign min_sat = (minutes > MINUTES_MAX) ? MINUTES_MAX : minutes;
  assign sec_sat = (seconds > SECONDS_MAX) ? SECONDS_MAX : seconds;
  assign ms_sat  = (millis  > MILLIS_MAX)  ? MILLIS_MAX  : millis;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      push     <= 1'b0;
    end else begin
      s1_valid <= accept;
      push     <= s1_valid;
    end
    {s1_min_hun, s1_min_rem} <= split_hun(min_sat);
    s1_secs                  <= sec_sat;
    {s1_ms_hun, s1_ms_rem}   <= split_hun(ms_sat);
    lap.mins.hun             <= s1_min_hun;
    {lap.mins.ten, lap.mins.unit} <= split_ten(s1_min_rem);
    lap.secs.hun             <= '0;
    {lap.secs.ten, lap.secs.unit} <= split_ten(REM_W'(s1_secs));
    lap.msec.hun             <= s1_ms_hun;
    {lap.msec.ten, lap.msec.unit} <= split_ten(s1_ms_rem);
  end

  assign pending = {1'b0, s1_valid} + {1'b0, push};

endmodule

>>> design/lts_queue.sv
// ----------------------------------------------------------------------------
// Lap time request queue
// Small first-in first-out buffer between the front end and the sequencer.
// ----------------------------------------------------------------------------
module lts_queue #(
  parameter int DEPTH = lts_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  lts_pkg::lap_t                wr_data,
  input  logic                         pop,
  output lts_pkg::lap_t                rd_data,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  import lts_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  lap_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  assign rd_data = slots[rd_ptr];
  assign empty   = (count == '0);

endmodule

>>> design/lts_back.sv
// ----------------------------------------------------------------------------
// Lap time clip sequencer
// Walks one classified request and emits one word clip per cycle, then
// takes the next request from the queue without a gap.
// ----------------------------------------------------------------------------
module lts_back (
  input  logic           clk,
  input  logic           rst,
  input  lts_pkg::lap_t  head,
  input  logic           q_empty,
  output logic           pop,
  output logic           strobe,
  output lts_pkg::clip_t clip,
  output logic           last
);
  import lts_pkg::*;

  typedef enum logic [3:0] {
    P_INTRO, P_MIN, P_MZ1, P_MZ2, P_MSEP, P_SEC, P_POINT, P_PAD1, P_PAD2, P_MS
  } phase_t;

  typedef enum logic [2:0] {
    N_HUN, N_HE, N_TEN, N_TE, N_UNIT
  } step_t;

  function automatic step_t first_step(digits_t d);
    return (d.hun != '0) ? N_HUN : N_TEN;
  endfunction

  logic    active;
  lap_t    cur;
  phase_t  phase;
  phase_t  phase_next;
  step_t   step;
  step_t   step_next;
  digits_t num;
  logic    rem_nz;
  clip_t   spk_clip;
  logic    spk_done;
  step_t   spk_next;
  clip_t   clip_next;
  logic    done_item;

  // Speaks one number digit group per step.
  always_comb begin
    unique case (phase)
      P_MIN:   num = cur.mins;
      P_SEC:   num = cur.secs;
      default: num = cur.msec;
    endcase
    rem_nz   = (num.ten != '0) || (num.unit != '0);
    spk_clip = clip_t'(num.unit);
    spk_done = 1'b1;
    spk_next = N_UNIT;
    unique case (step)
      N_HUN: begin
        spk_done = !rem_nz;
        if (num.hun == DIGIT_W'(1)) begin
          spk_clip = rem_nz ? CLIP_CENTO_E : CLIP_HUNDRED;
          spk_next = N_TEN;
        end else begin
          spk_clip = CLIP_HUNDREDS_BASE + clip_t'(num.hun) - clip_t'(2);
          spk_next = N_HE;
        end
      end
      N_HE: begin
        spk_clip = CLIP_E;
        spk_done = 1'b0;
        spk_next = N_TEN;
      end
      N_TEN: begin
        if (num.ten >= DIGIT_W'(2)) begin
          spk_clip = CLIP_TENS_BASE + clip_t'(num.ten) - clip_t'(2);
          spk_done = (num.unit == '0);
          spk_next = N_TE;
        end else begin
          spk_clip = (num.ten != '0) ? CLIP_TEN + clip_t'(num.unit) : clip_t'(num.unit);
        end
      end
      N_TE: begin
        spk_clip = CLIP_E;
        spk_done = 1'b0;
      end
      N_UNIT: begin
        spk_clip = clip_t'(num.unit);
      end
      default: begin
        spk_done = 1'b1;
      end
    endcase
  end

  // Announcement order.
  always_comb begin
    clip_next  = spk_clip;
    phase_next = phase;
    step_next  = step;
    done_item  = 1'b0;
    unique case (phase)
      P_INTRO: begin
        clip_next = CLIP_INTRO;
        if (cur.mins != '0) begin
          phase_next = P_MIN;
          step_next  = first_step(cur.mins);
        end else begin
          phase_next = P_SEC;
          step_next  = first_step(cur.secs);
        end
      end
      P_MIN: begin
        if (spk_done) begin
          phase_next = (cur.secs == '0) ? P_MZ1 : P_MSEP;
        end else begin
          step_next = spk_next;
        end
      end
      P_MZ1: begin
        clip_next  = CLIP_ZERO;
        phase_next = P_MZ2;
      end
      P_MZ2: begin
        clip_next  = CLIP_ZERO;
        phase_next = P_POINT;
      end
      P_MSEP: begin
        clip_next  = CLIP_E;
        phase_next = P_SEC;
        step_next  = first_step(cur.secs);
      end
      P_SEC: begin
        if (spk_done) begin
          phase_next = P_POINT;
        end else begin
          step_next = spk_next;
        end
      end
      P_POINT: begin
        clip_next = CLIP_POINT;
        step_next = first_step(cur.msec);
        if (cur.msec.hun != '0) begin
          phase_next = P_MS;
        end else if (cur.msec.ten != '0) begin
          phase_next = P_PAD2;
        end else begin
          phase_next = P_PAD1;
        end
      end
      P_PAD1: begin
        clip_next  = CLIP_ZERO;
        phase_next = P_PAD2;
      end
      P_PAD2: begin
        clip_next  = CLIP_ZERO;
        phase_next = P_MS;
        step_next  = first_step(cur.msec);
      end
      P_MS: begin
        if (spk_done) begin
          done_item = active;
        end else begin
          step_next = spk_next;
        end
      end
      default: begin
        phase_next = P_INTRO;
      end
    endcase
  end

  assign pop = !q_empty && (!active || done_item);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      phase  <= P_INTRO;
      step   <= N_HUN;
      strobe <= 1'b0;
      last   <= 1'b0;
    end else begin
      strobe <= active;
      last   <= done_item;
      if (pop) begin
        active <= 1'b1;
        cur    <= head;
        phase  <= P_INTRO;
        step   <= N_HUN;
      end else if (done_item) begin
        active <= 1'b0;
      end else if (active) begin
        phase <= phase_next;
        step  <= step_next;
      end
    end
    clip <= clip_next;
  end

endmodule

>>> design/lap_time_speech_sequencer.sv
// ----------------------------------------------------------------------------
// Lap time speech sequencer
// Turns a lap time into the ordered run of Portuguese word clips that
// announce it, one clip per cycle.
// ----------------------------------------------------------------------------
// A request (minutes, seconds, millis) is taken at a rising edge where start
// is high and busy is low. The block answers with 4 to 16 clips, one per
// cycle, each shown on clip and last for a single cycle with strobe high;
// last marks the final clip of the announcement. The receiver cannot stall,
// so every clip must be taken when it appears. When the block is idle, the
// first digit split is registered at the accepting edge, followed in order by
// the second split stage, the queue write, the sequencer load and the output
// register, which then shows the intro clip. The sustained rate is one clip
// per cycle, set by the clip sequencer, and an announcement waiting in the
// queue follows the previous one without a gap. Requests are held in a queue
// of QUEUE_DEPTH entries (counting those still being split), and busy rises
// only when that queue is full. Minutes and milliseconds above 999 and
// seconds above 59 are saturated before they are spoken.
// ----------------------------------------------------------------------------
module lap_time_speech_sequencer #(
  parameter int QUEUE_DEPTH = lts_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [lts_pkg::MINUTES_W-1:0] minutes,
  input  logic [lts_pkg::SECONDS_W-1:0] seconds,
  input  logic [lts_pkg::MILLIS_W-1:0]  millis,
  output logic                          strobe,
  output logic [lts_pkg::CLIP_W-1:0]    clip,
  output logic                          last
);
  import lts_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             accept;
  logic             push;
  lap_t             front_lap;
  logic [1:0]       pending;
  lap_t             head;
  logic             q_empty;
  logic [CNT_W-1:0] q_count;
  logic             pop;
  clip_t            clip_q;

  // A request is taken only while the queue, counting requests still in the
  // front end, has room for it, so a push never finds the queue full.
  assign busy   = ((CNT_W+2)'(q_count) + (CNT_W+2)'(pending)) >= (CNT_W+2)'(QUEUE_DEPTH);
  assign accept = start && !busy;

  // Front end: saturation and decimal digit split.
  lts_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .minutes (minutes),
    .seconds (seconds),
    .millis  (millis),
    .push    (push),
    .lap     (front_lap),
    .pending (pending)
  );

  // Queue between the front end and the sequencer.
  lts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (front_lap),
    .pop     (pop),
    .rd_data (head),
    .empty   (q_empty),
    .count   (q_count)
  );

  // Back end: one clip per cycle.
  lts_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .strobe  (strobe),
    .clip    (clip_q),
    .last    (last)
  );

  assign clip = clip_q;

endmodule

>>> design/lts_checker.sv
// ----------------------------------------------------------------------------
// Lap time speech sequencer checker
// Watches the top level's ports for the framing of announcements.
// ----------------------------------------------------------------------------
module lts_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       busy,
  input logic                       strobe,
  input logic [lts_pkg::CLIP_W-1:0] clip,
  input logic                       last
);
  import lts_pkg::*;

  // Reset leaves the block empty and ready.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe && !busy)
    else $error("strobe or busy high after reset");

  // An announcement ends on a spoken number, never on a connective or marker.
  a_last_clip: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> (clip != CLIP_E && clip != CLIP_POINT &&
                          clip != CLIP_INTRO && clip != CLIP_CENTO_E))
    else $error("announcement ends on a non-number clip");

  // An intro clip only opens an announcement.
  a_intro_first: assert property (@(posedge clk) disable iff (rst)
    (strobe && clip == CLIP_INTRO) |-> (!$past(strobe) || $past(last)))
    else $error("intro clip inside an announcement");

  // After the final clip, the next clip seen directly is a new intro.
  a_after_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> (!strobe || clip == CLIP_INTRO))
    else $error("clip after last is not an intro");

  // The decimal point is always followed at once by the milliseconds.
  a_point_cont: assert property (@(posedge clk) disable iff (rst)
    (strobe && clip == CLIP_POINT) |=> strobe)
    else $error("gap after decimal point clip");

endmodule

bind lap_time_speech_sequencer lts_checker u_lts_checker (
  .clk    (clk),
  .rst    (rst),
  .busy   (busy),
  .strobe (strobe),
  .clip   (clip),
  .last   (last)
);

>>> dv/lts_clip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap time speech sequencer clip checker
// Watches the request and clip ports and works out the clip run for each
// accepted request. Every clip is compared with the oldest clip still due.
// Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module lts_clip_checker
  import lts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [MINUTES_W-1:0] minutes,
  input  logic [SECONDS_W-1:0] seconds,
  input  logic [MILLIS_W-1:0]  millis,
  input  logic                 strobe,
  input  logic [CLIP_W-1:0]    clip,
  input  logic                 last,
  output int unsigned          fail_count,
  output int unsigned          clips_pending
);

  localparam int MAX_CLIPS   = 16;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    clip_t code;
    logic  is_last;
  } spoken_clip_t;

  clip_t        phrase[$];
  spoken_clip_t clips_due[$];
  int unsigned  mismatches = 0;
  int unsigned  due_count  = 0;

  assign fail_count    = mismatches;
  assign clips_pending = due_count;

  function automatic void say(clip_t code);
    if (phrase.size() < MAX_CLIPS) phrase.push_back(code);
  endfunction

  function automatic void say_below_hundred(int unsigned v);
    if (v >= 20) begin
      say(clip_t'(CLIP_TENS_BASE + v / 10 - 2));
      if (v % 10 != 0) begin
        say(CLIP_E);
        say(clip_t'(v % 10));
      end
    end else begin
      say(clip_t'(v));
    end
  endfunction

  // Numbers from 0 to 999; exactly one hundred has a clip of its own and
  // 101 to 199 start with the combined "cento e" clip.
  function automatic void say_number(int unsigned v);
    int unsigned hundreds;
    int unsigned rest;
    hundreds = v / 100;
    rest     = v % 100;
    if (v == 100) begin
      say(CLIP_HUNDRED);
    end else if (hundreds == 1) begin
      say(CLIP_CENTO_E);
      say_below_hundred(rest);
    end else if (hundreds >= 2) begin
      say(clip_t'(CLIP_HUNDREDS_BASE + hundreds - 2));
      if (rest != 0) begin
        say(CLIP_E);
        say_below_hundred(rest);
      end
    end else begin
      say_below_hundred(v);
    end
  endfunction

  function automatic void announce_lap(logic [MINUTES_W-1:0] m, logic [SECONDS_W-1:0] s,
                                       logic [MILLIS_W-1:0] ms);
    int unsigned  mins;
    int unsigned  secs;
    int unsigned  msec;
    spoken_clip_t item;
    mins = 32'((m > MINUTES_MAX) ? MINUTES_MAX : m);
    secs = 32'((s > SECONDS_MAX) ? SECONDS_MAX : s);
    msec = 32'((ms > MILLIS_MAX) ? MILLIS_MAX : ms);
    phrase.delete();
    say(CLIP_INTRO);
    if (mins != 0) begin
      say_number(mins);
      // Whole minutes are followed by two spoken zeros instead of the seconds.
      if (secs == 0) begin
        say(CLIP_ZERO);
        say(CLIP_ZERO);
      end else begin
        say(CLIP_E);
        say_number(secs);
      end
    end else begin
      say_number(secs);
    end
    say(CLIP_POINT);
    if (msec < 10) begin
      say(CLIP_ZERO);
      say(CLIP_ZERO);
    end else if (msec < 100) begin
      say(CLIP_ZERO);
    end
    say_number(msec);
    foreach (phrase[i]) begin
      item.code    = phrase[i];
      item.is_last = (i == phrase.size() - 1);
      clips_due.push_back(item);
    end
  endfunction

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t clip check: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    spoken_clip_t want;
    if (rst) begin
      clips_due.delete();
    end else begin
      if (strobe !== 1'b0) begin
        if (clips_due.size() == 0) begin
          report($sformatf("clip %0d (last %b) with none due", clip, last));
        end else begin
          want = clips_due.pop_front();
          if (strobe !== 1'b1 || clip !== want.code)
            report($sformatf("clip expected %0d got %0d", want.code, clip));
          if (last !== want.is_last)
            report($sformatf("last expected %b got %b on clip %0d", want.is_last, last,
                             want.code));
        end
      end
      if (start && !busy) announce_lap(minutes, seconds, millis);
    end
    due_count = clips_due.size();
  end

endmodule

>>> dv/lap_time_speech_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap time speech sequencer testbench
// Sends lap time requests, first a directed set covering the corners of the
// spoken number scheme and then random requests with random spacing, while
// the clip checker predicts and compares every clip the block speaks.
// ----------------------------------------------------------------------------
module lap_time_speech_sequencer_tb;

  import lts_pkg::*;

  localparam int CLK_PERIOD_NS   = 20;
  localparam int RESET_CYCLES    = 9;
  localparam int RANDOM_REQUESTS = 450;
  // The intro clip trails a taken request through the pipeline and a run is
  // at most sixteen clips; this is ample for anything still in flight.
  localparam int DRAIN_CYCLES    = 40;
  // Slowest correct run: about 470 requests, each with up to sixteen clips
  // and the longest sender gap, stays far below this limit.
  localparam int CYCLE_LIMIT     = 300000;

  logic                 clk     = 1'b0;
  logic                 rst     = 1'b1;
  logic                 start   = 1'b0;
  logic [MINUTES_W-1:0] minutes = '0;
  logic [SECONDS_W-1:0] seconds = '0;
  logic [MILLIS_W-1:0]  millis  = '0;
  logic                 busy;
  logic                 strobe;
  logic [CLIP_W-1:0]    clip;
  logic                 last;

  int unsigned fail_count;
  int unsigned clips_pending;
  int unsigned cycle_count = 0;

  lap_time_speech_sequencer u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .minutes (minutes),
    .seconds (seconds),
    .millis  (millis),
    .strobe  (strobe),
    .clip    (clip),
    .last    (last)
  );

  // The checker sits beside the block and sees exactly what the block sees.
  lts_clip_checker u_clip_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .minutes       (minutes),
    .seconds       (seconds),
    .millis        (millis),
    .strobe        (strobe),
    .clip          (clip),
    .last          (last),
    .fail_count    (fail_count),
    .clips_pending (clips_pending)
  );

  initial begin
    forever #(CLK_PERIOD_NS / 2) clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing clip ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[lap_time_speech_sequencer] ERROR");
      $finish;
    end
  end

  // Most gaps are short, a few are long enough to let the block drain
  // completely, so idle time lands on every phase of a clip run.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Zero minutes take the short path through the announcement, so they get
  // a large share; values above 999 check saturation.
  function automatic logic [MINUTES_W-1:0] pick_minutes();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return '0;
    if (r < 35) return MINUTES_W'($urandom_range(0, 1023));
    if (r < 45) return MINUTES_W'($urandom_range(100, 199));
    return MINUTES_W'($urandom_range(1, 999));
  endfunction

  // Zero seconds change what follows the minutes; 60 to 63 saturate.
  function automatic logic [SECONDS_W-1:0] pick_seconds();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return SECONDS_W'($urandom_range(0, 63));
    return SECONDS_W'($urandom_range(1, 59));
  endfunction

  // Milliseconds below 100 are padded with spoken zeros, so both padded
  // ranges are weighted up next to the three-digit values.
  function automatic logic [MILLIS_W-1:0] pick_millis();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return MILLIS_W'($urandom_range(0, 9));
    if (r < 30) return MILLIS_W'($urandom_range(10, 99));
    if (r < 40) return MILLIS_W'($urandom_range(0, 1023));
    return MILLIS_W'($urandom_range(100, 999));
  endfunction

  // Presents one request and holds it until the block takes it. With no gap
  // start simply stays high into the next request, so it is never lowered
  // and raised in the same time step.
  task automatic request_lap(input logic [MINUTES_W-1:0] m, input logic [SECONDS_W-1:0] s,
                             input logic [MILLIS_W-1:0] ms, input int unsigned gap);
    minutes <= m;
    seconds <= s;
    millis  <= ms;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int unsigned calm_left;
    int unsigned gap;
    calm_left = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests: an all-zero time (a lone zero for the
    // seconds and fully padded milliseconds), whole minutes, exactly one
    // hundred, the "cento e" range, teens, tens, hundreds with and without
    // a remainder, the longest runs and saturation of every field.
    request_lap(10'd0,    6'd0,  10'd0,    pick_gap());
    request_lap(10'd0,    6'd59, 10'd999,  pick_gap());
    request_lap(10'd1,    6'd0,  10'd5,    pick_gap());
    request_lap(10'd100,  6'd1,  10'd100,  pick_gap());
    request_lap(10'd101,  6'd10, 10'd101,  pick_gap());
    request_lap(10'd199,  6'd19, 10'd199,  pick_gap());
    request_lap(10'd110,  6'd21, 10'd120,  pick_gap());
    request_lap(10'd200,  6'd20, 10'd10,   pick_gap());
    request_lap(10'd300,  6'd45, 10'd900,  pick_gap());
    request_lap(10'd777,  6'd57, 10'd777,  pick_gap());
    request_lap(10'd999,  6'd59, 10'd99,   pick_gap());
    request_lap(10'd1023, 6'd63, 10'd1023, pick_gap());
    request_lap(10'd512,  6'd32, 10'd512,  pick_gap());
    request_lap(10'd0,    6'd60, 10'd50,   pick_gap());
    request_lap(10'd0,    6'd7,  10'd7,    pick_gap());
    request_lap(10'd341,  6'd38, 10'd910,  pick_gap());
    request_lap(10'd1000, 6'd0,  10'd1000, pick_gap());
    request_lap(10'd0,    6'd1,  10'd19,   0);
    request_lap(10'd20,   6'd30, 10'd40,   0);
    request_lap(10'd905,  6'd15, 10'd250,  pick_gap());

    // Random requests. Now and then a stretch goes out back to back so the
    // request queue fills up and busy has to hold the sender off.
    repeat (RANDOM_REQUESTS) begin
      if (calm_left > 0) begin
        calm_left--;
        gap = 0;
      end else begin
        gap = pick_gap();
        if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(8, 20);
      end
      request_lap(pick_minutes(), pick_seconds(), pick_millis(), gap);
    end
    start <= 1'b0;
    @(posedge clk);

    // Wait for every predicted clip, then a while longer so that a stray
    // extra clip is caught as well.
    while (clips_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && clips_pending == 0) begin
      $display("[lap_time_speech_sequencer] OK");
    end else begin
      $display("[lap_time_speech_sequencer] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
design/lts_pkg.sv
design/lts_front.sv
design/lts_queue.sv
design/lts_back.sv
design/lap_time_speech_sequencer.sv
design/lts_checker.sv
dv/lts_clip_checker.sv
dv/lap_time_speech_sequencer_tb.sv
